FILE: src/tgst_pkg.sv
// ---------------------------------------------------------------------------
// tgst_pkg
// Shared types and constants of the touch gesture session tracker.
// ---------------------------------------------------------------------------
package tgst_pkg;

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned TimeW     = 64;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned SeqW      = 32;
  localparam int unsigned DurW      = 32;
  localparam int unsigned RunW      = 8;

  localparam logic [RunW-1:0]     ReleaseConfirmRst = 8'd2;
  localparam logic [CfgDataW-1:0] UnknownHoldRst    = 16'd100;
  localparam logic [CfgDataW-1:0] TapSlopRst        = 16'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RELEASE_CONFIRM = 2'd0,
    CFG_UNKNOWN_HOLD    = 2'd1,
    CFG_TAP_SLOP        = 2'd2,
    CFG_NONE            = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_UNKNOWN = 2'd2,
    OP_CLAIM   = 2'd3
  } op_e;

  typedef struct packed {
    logic [RunW-1:0]     release_confirm_count;
    logic [CfgDataW-1:0] unknown_hold_ms;
    logic [CfgDataW-1:0] tap_slop_px;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              operation;
    logic signed [CoordW-1:0] touch_x;
    logic signed [CoordW-1:0] touch_y;
    logic [TimeW-1:0]        time_ms;
  } in_word_t;

  typedef struct packed {
    logic [SeqW-1:0]          seq_id;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic                     is_pressed;
    logic                     started_now;
    logic                     finished_now;
    logic                     was_cancelled;
    logic                     tap_ok;
    logic                     nav_granted;
    logic                     is_drag;
    logic [DurW-1:0]          hold_duration_ms;
    logic                     have_session;
  } out_word_t;

endpackage

FILE: src/tgst_cfg_regs.sv
// ---------------------------------------------------------------------------
// tgst_cfg_regs
// Configuration registers of the tracker, written through a plain write port.
// ---------------------------------------------------------------------------
module tgst_cfg_regs import tgst_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RELEASE_CONFIRM: cfg_d.release_confirm_count = cfg_wdata_i[RunW-1:0];
        CFG_UNKNOWN_HOLD:    cfg_d.unknown_hold_ms       = cfg_wdata_i;
        CFG_TAP_SLOP:        cfg_d.tap_slop_px           = cfg_wdata_i;
        CFG_NONE:            cfg_d = cfg_q;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.release_confirm_count <= ReleaseConfirmRst;
      cfg_q.unknown_hold_ms       <= UnknownHoldRst;
      cfg_q.tap_slop_px           <= TapSlopRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/tgst_session_engine.sv
// ---------------------------------------------------------------------------
// tgst_session_engine
// Session state and the single-pass update for one sample word.
// ---------------------------------------------------------------------------
module tgst_session_engine import tgst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      fire_i,
  input  in_word_t  word_i,
  output out_word_t res_o
);

  logic                     active_q, active_d;
  logic                     seen_q, seen_d;
  logic                     drag_q, drag_d;
  logic                     cancel_q, cancel_d;
  logic                     nav_q, nav_d;
  logic [SeqW-1:0]          seq_q, seq_d;
  logic signed [CoordW-1:0] start_x_q, start_x_d, start_y_q, start_y_d;
  logic signed [CoordW-1:0] end_x_q, end_x_d, end_y_q, end_y_d;
  logic [CoordW-1:0]        dev_x_q, dev_x_d, dev_y_q, dev_y_d;
  logic [TimeW-1:0]         press_time_q, press_time_d;
  logic [TimeW-1:0]         good_time_q, good_time_d;
  logic [RunW-1:0]          run_q, run_d;
  logic [DurW-1:0]          dur_q, dur_d;

  logic                     started, finished, cancelled, granted;
  logic [SeqW-1:0]          seq_inc;
  logic signed [CoordW:0]   diff_x, diff_y;
  logic [CoordW:0]          abs_x, abs_y;
  logic [CoordW-1:0]        dev_x_new, dev_y_new;
  logic [TimeW:0]           dur_diff, gap_diff;
  logic [DurW-1:0]          dur_val;
  logic                     hold_press;
  logic [RunW-1:0]          run_inc;

  assign seq_inc   = seq_q + 1'b1;
  assign diff_x    = {word_i.touch_x[CoordW-1], word_i.touch_x}
                   - {start_x_q[CoordW-1], start_x_q};
  assign diff_y    = {word_i.touch_y[CoordW-1], word_i.touch_y}
                   - {start_y_q[CoordW-1], start_y_q};
  assign abs_x     = diff_x[CoordW] ? (CoordW+1)'(-diff_x) : diff_x;
  assign abs_y     = diff_y[CoordW] ? (CoordW+1)'(-diff_y) : diff_y;
  assign dev_x_new = (abs_x[CoordW-1:0] > dev_x_q) ? abs_x[CoordW-1:0] : dev_x_q;
  assign dev_y_new = (abs_y[CoordW-1:0] > dev_y_q) ? abs_y[CoordW-1:0] : dev_y_q;

  assign dur_diff  = {1'b0, word_i.time_ms} - {1'b0, press_time_q};
  assign dur_val   = dur_diff[TimeW] ? '0 :
                     (|dur_diff[TimeW-1:DurW]) ? '1 : dur_diff[DurW-1:0];
  assign gap_diff  = {1'b0, word_i.time_ms} - {1'b0, good_time_q};
  assign hold_press = gap_diff[TimeW] ||
                      (gap_diff[TimeW-1:0] < {{(TimeW-CfgDataW){1'b0}}, cfg_i.unknown_hold_ms});
  assign run_inc   = (run_q == '1) ? run_q : run_q + 1'b1;

  always_comb begin
    active_d     = active_q;
    seen_d       = seen_q;
    drag_d       = drag_q;
    cancel_d     = cancel_q;
    nav_d        = nav_q;
    seq_d        = seq_q;
    start_x_d    = start_x_q;
    start_y_d    = start_y_q;
    end_x_d      = end_x_q;
    end_y_d      = end_y_q;
    dev_x_d      = dev_x_q;
    dev_y_d      = dev_y_q;
    press_time_d = press_time_q;
    good_time_d  = good_time_q;
    run_d        = run_q;
    dur_d        = dur_q;
    started      = 1'b0;
    finished     = 1'b0;
    cancelled    = 1'b0;
    granted      = 1'b0;
    unique case (op_e'(word_i.operation))
      OP_PRESS: begin
        end_x_d     = word_i.touch_x;
        end_y_d     = word_i.touch_y;
        good_time_d = word_i.time_ms;
        run_d       = '0;
        if (!active_q) begin
          seq_d        = (seq_inc == '0) ? SeqW'(1) : seq_inc;
          start_x_d    = word_i.touch_x;
          start_y_d    = word_i.touch_y;
          dev_x_d      = '0;
          dev_y_d      = '0;
          drag_d       = 1'b0;
          cancel_d     = 1'b0;
          nav_d        = 1'b0;
          active_d     = 1'b1;
          seen_d       = 1'b1;
          press_time_d = word_i.time_ms;
          dur_d        = '0;
          started      = 1'b1;
        end else begin
          dev_x_d = dev_x_new;
          dev_y_d = dev_y_new;
          if (dev_x_new >= cfg_i.tap_slop_px || dev_y_new >= cfg_i.tap_slop_px) begin
            drag_d = 1'b1;
          end
        end
      end
      OP_RELEASE: begin
        if (active_q) begin
          good_time_d = word_i.time_ms;
          run_d       = run_inc;
          if (run_inc >= cfg_i.release_confirm_count) begin
            active_d = 1'b0;
            cancel_d = 1'b0;
            dur_d    = dur_val;
            run_d    = '0;
            finished = 1'b1;
          end
        end
      end
      OP_UNKNOWN: begin
        if (active_q && !hold_press) begin
          active_d  = 1'b0;
          cancel_d  = 1'b1;
          dur_d     = dur_val;
          run_d     = '0;
          finished  = 1'b1;
          cancelled = 1'b1;
        end
      end
      OP_CLAIM: begin
        if (seen_q && !active_q && drag_q && !cancel_q && !nav_q) begin
          nav_d   = 1'b1;
          granted = 1'b1;
        end
      end
      default: begin
        active_d = active_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      seen_q       <= 1'b0;
      drag_q       <= 1'b0;
      cancel_q     <= 1'b0;
      nav_q        <= 1'b0;
      seq_q        <= '0;
      start_x_q    <= '0;
      start_y_q    <= '0;
      end_x_q      <= '0;
      end_y_q      <= '0;
      dev_x_q      <= '0;
      dev_y_q      <= '0;
      press_time_q <= '0;
      good_time_q  <= '0;
      run_q        <= '0;
      dur_q        <= '0;
    end else if (fire_i) begin
      active_q     <= active_d;
      seen_q       <= seen_d;
      drag_q       <= drag_d;
      cancel_q     <= cancel_d;
      nav_q        <= nav_d;
      seq_q        <= seq_d;
      start_x_q    <= start_x_d;
      start_y_q    <= start_y_d;
      end_x_q      <= end_x_d;
      end_y_q      <= end_y_d;
      dev_x_q      <= dev_x_d;
      dev_y_q      <= dev_y_d;
      press_time_q <= press_time_d;
      good_time_q  <= good_time_d;
      run_q        <= run_d;
      dur_q        <= dur_d;
    end
  end

  always_comb begin
    res_o.seq_id           = seq_d;
    res_o.pos_x            = end_x_d;
    res_o.pos_y            = end_y_d;
    res_o.is_pressed       = seen_d && active_d;
    res_o.started_now      = started;
    res_o.finished_now     = finished;
    res_o.was_cancelled    = cancelled;
    res_o.tap_ok           = !seen_d || (!active_d && !drag_d && !cancel_d && !nav_d);
    res_o.nav_granted      = granted;
    res_o.is_drag          = drag_d;
    res_o.hold_duration_ms = dur_d;
    res_o.have_session     = seen_d;
  end

endmodule

FILE: src/touch_gesture_session_tracker_core.sv
// ---------------------------------------------------------------------------
// touch_gesture_session_tracker_core
// Tracks touch press sessions, tap and drag state and navigation claims.
//
//   channel  direction  handshake              word
//   in       input      in_valid_i/in_stall_o   in_word_t
//   out      output     out_valid_o/out_stall_i out_word_t
//   cfg      input      cfg_we_i                cfg_index_i, cfg_wdata_i
//
// One word per cycle while the output does not stall; the result passes through
// the input register, then the session update into the result register.
// Reset clears the session state and loads the register defaults.
// A stall on the output holds the result and backs up into the input register.
// ---------------------------------------------------------------------------
module touch_gesture_session_tracker_core import tgst_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_word_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t      cfg;
  in_word_t  s1_word_q;
  logic      s1_valid_q, s1_valid_d;
  out_word_t res;
  out_word_t out_word_q;
  logic      out_valid_q, out_valid_d;
  logic      out_free, fire, in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept ? 1'b1 : (fire ? 1'b0 : s1_valid_q);
  assign out_valid_d = fire ? 1'b1 : (out_free ? 1'b0 : out_valid_q);

  tgst_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tgst_session_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (fire),
    .word_i (s1_word_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_word_q <= in_word_i;
    end
    if (fire) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for touch_gesture_session_tracker_core.
// A short table of words covers idle samples, coordinate and time extremes,
// drag, claim, unknown-sample timeout and time running backwards. After it
// comes gesture-shaped random traffic with some noise, under six register
// settings. Both ports idle and stall at random. Every result word is compared
// field by field against a table entry or an in-bench session tracker.
// ----------------------------------------------------------------------------
module tb_top;
  import tgst_pkg::*;

  typedef struct packed {
    op_e                      op;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [TimeW-1:0]         t;
    logic                     typed;
    out_word_t                want;
  } plan_row_t;

  localparam out_word_t Untouched = '{32'd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0,
                                      1'b1, 1'b0, 1'b0, 32'd0, 1'b0};

  localparam plan_row_t Plan [25] = '{
    '{OP_RELEASE, 16'sd0, 16'sd0, 64'd5, 1'b1, Untouched},
    '{OP_UNKNOWN, 16'sd0, 16'sd0, 64'd6, 1'b1, Untouched},
    '{OP_CLAIM, 16'sd0, 16'sd0, 64'd7, 1'b1, Untouched},
    '{OP_PRESS, 16'sh8000, 16'sh7fff, 64'd10, 1'b1,
      '{32'd1, 16'sh8000, 16'sh7fff, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b1}},
    '{OP_PRESS, 16'sh7fff, 16'sh7fff, 64'd20, 1'b1,
      '{32'd1, 16'sh7fff, 16'sh7fff, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 32'd0, 1'b1}},
    '{OP_RELEASE, 16'sd0, 16'sd0, 64'd30, 1'b0, '0},
    '{OP_PRESS, 16'sd0, 16'sd0, 64'd40, 1'b0, '0},
    '{OP_RELEASE, 16'sd0, 16'sd0, 64'd50, 1'b0, '0},
    '{OP_RELEASE, 16'sd0, 16'sd0, 64'd60, 1'b1,
      '{32'd1, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 32'd50, 1'b1}},
    '{OP_CLAIM, 16'sd0, 16'sd0, 64'd61, 1'b1,
      '{32'd1, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 32'd50, 1'b1}},
    '{OP_CLAIM, 16'sd0, 16'sd0, 64'd62, 1'b0, '0},
    '{OP_PRESS, 16'sd100, -16'sd100, 64'd1000, 1'b0, '0},
    '{OP_UNKNOWN, 16'sd0, 16'sd0, 64'd1050, 1'b0, '0},
    '{OP_UNKNOWN, 16'sd0, 16'sd0, 64'd900, 1'b0, '0},
    '{OP_UNKNOWN, 16'sd0, 16'sd0, 64'd1100, 1'b1,
      '{32'd2, 16'sd100, -16'sd100, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 32'd100, 1'b1}},
    '{OP_CLAIM, 16'sd0, 16'sd0, 64'd1101, 1'b0, '0},
    '{OP_PRESS, 16'sd5, 16'sd5, 64'd2000, 1'b0, '0},
    '{OP_PRESS, 16'sd14, -16'sd4, 64'd2001, 1'b0, '0},
    '{OP_PRESS, 16'sd5, 16'sd15, 64'd2002, 1'b0, '0},
    '{OP_RELEASE, 16'sd0, 16'sd0, 64'd1500, 1'b0, '0},
    '{OP_RELEASE, 16'sd0, 16'sd0, 64'd1600, 1'b1,
      '{32'd3, 16'sd5, 16'sd15, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 32'd0, 1'b1}},
    '{OP_PRESS, 16'sd1, 16'sd1, 64'd0, 1'b0, '0},
    '{OP_PRESS, 16'sd1, 16'sd1, 64'hffff_ffff_ffff_ffff, 1'b0, '0},
    '{OP_RELEASE, 16'sd0, 16'sd0, 64'hffff_ffff_ffff_ffff, 1'b0, '0},
    '{OP_RELEASE, 16'sd0, 16'sd0, 64'hffff_ffff_ffff_ffff, 1'b1,
      '{32'd4, 16'sd1, 16'sd1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 32'hffff_ffff, 1'b1}}
  };

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_word_t            in_word   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_word_t           out_word;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = CFG_RELEASE_CONFIRM;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  touch_gesture_session_tracker_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk = ~clk;

  cfg_t regs = '{ReleaseConfirmRst, UnknownHoldRst, TapSlopRst};

  logic                     trk_active  = 1'b0;
  logic                     trk_seen    = 1'b0;
  logic                     trk_drag    = 1'b0;
  logic                     trk_cancel  = 1'b0;
  logic                     trk_nav     = 1'b0;
  logic [SeqW-1:0]          trk_seq     = '0;
  logic signed [CoordW-1:0] trk_start_x = '0;
  logic signed [CoordW-1:0] trk_start_y = '0;
  logic signed [CoordW-1:0] trk_end_x   = '0;
  logic signed [CoordW-1:0] trk_end_y   = '0;
  logic [CoordW-1:0]        trk_dev_x   = '0;
  logic [CoordW-1:0]        trk_dev_y   = '0;
  logic [TimeW-1:0]         trk_t_press = '0;
  logic [TimeW-1:0]         trk_t_good  = '0;
  logic [RunW-1:0]          trk_run     = '0;
  logic [DurW-1:0]          trk_dur     = '0;

  out_word_t        reports [$];
  logic [TimeW-1:0] now_ms = '0;
  logic             tx_calm = 1'b0;
  logic             rx_calm = 1'b0;
  int unsigned      words_sent = 0;
  int unsigned      useful_words = 0;
  int unsigned      sessions_opened = 0;
  int unsigned      drags_ended = 0;
  int unsigned      timeouts = 0;
  int unsigned      grants = 0;
  int               mismatches = 0;

  function automatic void end_press(logic [TimeW-1:0] now, logic by_timeout);
    trk_active = 1'b0;
    trk_cancel = by_timeout;
    if (now < trk_t_press) trk_dur = '0;
    else if (now - trk_t_press > 64'hffff_ffff) trk_dur = '1;
    else trk_dur = DurW'(now - trk_t_press);
    trk_run = '0;
  endfunction

  function automatic out_word_t track_touch(in_word_t w);
    out_word_t        r;
    int               dx;
    int               dy;
    logic [TimeW-1:0] now;
    logic             started;
    logic             finished;
    logic             cancelled;
    logic             granted;
    now       = w.time_ms;
    started   = 1'b0;
    finished  = 1'b0;
    cancelled = 1'b0;
    granted   = 1'b0;
    case (op_e'(w.operation))
      OP_PRESS: begin
        if (!trk_active) begin
          trk_seq     = (trk_seq == '1) ? SeqW'(1) : trk_seq + 1'b1;
          trk_start_x = w.touch_x;
          trk_start_y = w.touch_y;
          trk_end_x   = w.touch_x;
          trk_end_y   = w.touch_y;
          trk_dev_x   = '0;
          trk_dev_y   = '0;
          trk_drag    = 1'b0;
          trk_cancel  = 1'b0;
          trk_nav     = 1'b0;
          trk_active  = 1'b1;
          trk_seen    = 1'b1;
          trk_t_press = now;
          trk_t_good  = now;
          trk_run     = '0;
          trk_dur     = '0;
          started     = 1'b1;
        end else begin
          trk_end_x  = w.touch_x;
          trk_end_y  = w.touch_y;
          trk_t_good = now;
          trk_run    = '0;
          dx = int'(w.touch_x) - int'(trk_start_x);
          dy = int'(w.touch_y) - int'(trk_start_y);
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          if (dx[15:0] > trk_dev_x) trk_dev_x = dx[15:0];
          if (dy[15:0] > trk_dev_y) trk_dev_y = dy[15:0];
          if (trk_dev_x >= regs.tap_slop_px || trk_dev_y >= regs.tap_slop_px) trk_drag = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (trk_active) begin
          trk_t_good = now;
          if (trk_run != '1) trk_run = trk_run + 1'b1;
          if (trk_run >= regs.release_confirm_count) begin
            end_press(now, 1'b0);
            finished = 1'b1;
          end
        end
      end
      OP_UNKNOWN: begin
        if (trk_active && now >= trk_t_good &&
            now - trk_t_good >= TimeW'(regs.unknown_hold_ms)) begin
          end_press(now, 1'b1);
          finished  = 1'b1;
          cancelled = 1'b1;
        end
      end
      default: begin
        if (trk_seen && !trk_active && trk_drag && !trk_cancel && !trk_nav) begin
          trk_nav = 1'b1;
          granted = 1'b1;
        end
      end
    endcase
    r.seq_id           = trk_seq;
    r.pos_x            = trk_end_x;
    r.pos_y            = trk_end_y;
    r.is_pressed       = trk_seen && trk_active;
    r.started_now      = started;
    r.finished_now     = finished;
    r.was_cancelled    = cancelled;
    r.tap_ok           = !trk_seen || (!trk_active && !trk_drag && !trk_cancel && !trk_nav);
    r.nav_granted      = granted;
    r.is_drag          = trk_drag;
    r.hold_duration_ms = trk_dur;
    r.have_session     = trk_seen;
    sessions_opened += started;
    timeouts        += cancelled;
    grants          += granted;
    drags_ended     += finished && trk_drag;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_word(out_word_t want, out_word_t got);
    check_field("seq_id", want.seq_id, got.seq_id);
    check_field("pos_x", want.pos_x, got.pos_x);
    check_field("pos_y", want.pos_y, got.pos_y);
    check_field("is_pressed", want.is_pressed, got.is_pressed);
    check_field("started_now", want.started_now, got.started_now);
    check_field("finished_now", want.finished_now, got.finished_now);
    check_field("was_cancelled", want.was_cancelled, got.was_cancelled);
    check_field("tap_ok", want.tap_ok, got.tap_ok);
    check_field("nav_granted", want.nav_granted, got.nav_granted);
    check_field("is_drag", want.is_drag, got.is_drag);
    check_field("hold_duration_ms", want.hold_duration_ms, got.hold_duration_ms);
    check_field("have_session", want.have_session, got.have_session);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (reports.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        check_word(reports.pop_front(), out_word);
      end
    end
  end

  initial begin
    int unsigned hold_cycles;
    forever begin
      if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
      hold_cycles = rx_calm ? 0 : $urandom_range(0, 16);
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_word(in_word_t w, logic typed, out_word_t typed_want);
    int unsigned gap;
    out_word_t   want;
    if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    if (!((w.operation == OP_RELEASE || w.operation == OP_UNKNOWN) && !trk_active))
      useful_words++;
    want = track_touch(w);
    reports.push_back(typed ? typed_want : want);
    words_sent++;
  endtask

  task automatic emit(op_e op, logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                      logic [TimeW-1:0] t);
    in_word_t w;
    w.operation = op;
    w.touch_x   = x;
    w.touch_y   = y;
    w.time_ms   = t;
    send_word(w, 1'b0, '0);
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (reports.size() != 0) @(posedge clk);
  endtask

  task automatic apply_setting(cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RELEASE_CONFIRM;
    cfg_wdata <= {8'($urandom), c.release_confirm_count};
    @(posedge clk);
    cfg_index <= CFG_UNKNOWN_HOLD;
    cfg_wdata <= c.unknown_hold_ms;
    @(posedge clk);
    cfg_index <= CFG_TAP_SLOP;
    cfg_wdata <= c.tap_slop_px;
    @(posedge clk);
    cfg_we <= 1'b0;
    regs = c;
  endtask

  task automatic play_gesture();
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] y0;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    int unsigned              span;
    int unsigned              confirm;
    x0 = ($urandom_range(0, 3) == 0) ? 16'sh8000 : 16'($urandom);
    y0 = 16'($urandom);
    case ($urandom_range(0, 3))
      0: span = 3;
      1: span = int'(regs.tap_slop_px) / 2 + 1;
      2: span = int'(regs.tap_slop_px) + 2;
      default: span = 0;
    endcase
    confirm = (regs.release_confirm_count == 0) ? 1 : regs.release_confirm_count;
    now_ms += $urandom_range(0, 50);
    emit(OP_PRESS, x0, y0, now_ms);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 9) == 0) now_ms -= $urandom_range(0, 60);
      else now_ms += $urandom_range(0, 30);
      if ($urandom_range(0, 4) == 0) begin
        now_ms += $urandom_range(0, int'(regs.unknown_hold_ms) * 3 / 2 + 2);
        emit(OP_UNKNOWN, 16'($urandom), 16'($urandom), now_ms);
      end else begin
        if (span == 0) begin
          x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          y = 16'($urandom);
        end else begin
          x = x0 + 16'($urandom_range(0, 2 * span) - span);
          y = y0 + 16'($urandom_range(0, 2 * span) - span);
        end
        emit(OP_PRESS, x, y, now_ms);
      end
    end
    if (confirm > 1 && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, (confirm > 5) ? 4 : confirm - 1)) begin
        now_ms += $urandom_range(0, 20);
        emit(OP_RELEASE, 16'($urandom), 16'($urandom), now_ms);
      end
      emit(OP_PRESS, x0, y0, now_ms);
    end
    repeat (confirm) begin
      now_ms += $urandom_range(0, 20);
      emit(OP_RELEASE, 16'($urandom), 16'($urandom), now_ms);
    end
    repeat ($urandom_range(0, 2)) emit(OP_CLAIM, 16'($urandom), 16'($urandom), now_ms);
  endtask

  initial begin
    cfg_t        settings [5];
    in_word_t    w;
    int unsigned goal;
    settings[0] = '{8'd1, 16'd0, 16'd0};
    settings[1] = '{8'd255, 16'd65535, 16'd65535};
    settings[2] = '{8'd0, 16'd1, 16'd1};
    settings[3] = '{8'd3, 16'd20, 16'd40};
    settings[4] = '{8'($urandom_range(1, 6)), 16'($urandom_range(0, 300)),
                    16'($urandom_range(0, 60))};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 25; i++) begin
      w = '{Plan[i].op, Plan[i].x, Plan[i].y, Plan[i].t};
      send_word(w, Plan[i].typed, Plan[i].want);
    end
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        drain_reports();
        apply_setting(settings[p-1]);
      end
      now_ms = (p % 2 == 1) ? {$urandom, $urandom} : 64'($urandom_range(0, 1000));
      goal = useful_words + 155;
      while (useful_words < goal) begin
        if ($urandom_range(0, 9) < 8) begin
          play_gesture();
        end else begin
          repeat ($urandom_range(1, 4))
            emit(op_e'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                 ($urandom_range(0, 7) == 0) ? {$urandom, $urandom}
                                             : now_ms + $urandom_range(0, 500));
        end
      end
    end
    drain_reports();
    repeat (4) @(posedge clk);
    $display("Sent %0d words under six register settings: %0d sessions opened, %0d drags ended,",
             words_sent, sessions_opened, drags_ended);
    $display("%0d presses dropped on unknown-sample timeout, %0d navigation claims granted.",
             timeouts, grants);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d result words outstanding", reports.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: touch_gesture_session_tracker_core.f
src/tgst_pkg.sv
src/tgst_cfg_regs.sv
src/tgst_session_engine.sv
src/touch_gesture_session_tracker_core.sv
tb/sv/tb_top.sv
